// ----- rtl/lebfl_pkg.sv -----
// package for the fixed-length leb128 encoder
// holds the length limits, byte constants and the sequencer state type
// no dependencies
package lebfl_pkg;

  localparam int MAX_FIXED_LENGTH = 16;
  localparam int LEN_W            = $clog2(MAX_FIXED_LENGTH + 1);
  localparam int MINIMAL_CAP      = 10;

  localparam logic [6:0] LOW7_MASK = 7'h7F;
  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [6:0] SIGN_BIT6 = 7'h40;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

// ----- rtl/leb128_encoder_fixed_length.sv -----
// Takes one 64-bit value with a signed/unsigned mode and a requested length and
// emits its LEB128 encoding one byte per output word, low seven bits first.
// A requested length of 0 gives the minimal encoding (at most ten bytes);
// otherwise exactly that many bytes are emitted, with requests above
// MAX_FIXED_LENGTH saturated to it. If the value does not fit, the final byte
// carries length_error. The block takes one value at a time: it loads the value,
// then emits one byte per cycle while the output is not stalled, taken from the
// shared 64-bit shift register (which drops seven bits per byte) and its
// stop-rule compare. in_stall stays high from load until the last byte has
// been handed to the output register. Depends on lebfl_pkg.
module leb128_encoder_fixed_length (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  input  logic        signed_mode,
  input  logic [4:0]  requested_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic        length_error
);

  lebfl_pkg::state_t state;
  logic [63:0] v;
  logic        sgn;
  logic [lebfl_pkg::LEN_W-1:0] len;
  logic [lebfl_pkg::LEN_W-1:0] cnt;

  logic [lebfl_pkg::LEN_W-1:0] len_next;
  logic [lebfl_pkg::LEN_W-1:0] cnt_inc;
  logic [6:0]  byte_lo;
  logic [63:0] rest;
  logic        stop;
  logic        minimal;
  logic        is_last;
  logic        out_free;
  logic        fire;
  logic        accept;

  always_comb begin
    if (32'(requested_length) > lebfl_pkg::MAX_FIXED_LENGTH) begin
      len_next = lebfl_pkg::LEN_W'(lebfl_pkg::MAX_FIXED_LENGTH);
    end else begin
      len_next = lebfl_pkg::LEN_W'(requested_length);
    end
  end

  // shared shift and stop-rule unit
  always_comb begin
    byte_lo = v[6:0] & lebfl_pkg::LOW7_MASK;
    rest    = sgn ? {{7{v[63]}}, v[63:7]} : {7'b0, v[63:7]};
    if (sgn && ((byte_lo & lebfl_pkg::SIGN_BIT6) != 7'b0)) begin
      stop = (rest == '1);
    end else begin
      stop = (rest == '0);
    end
    minimal = (len == '0);
    cnt_inc = cnt + lebfl_pkg::LEN_W'(1);
    if (minimal) begin
      is_last = stop || (cnt_inc == lebfl_pkg::LEN_W'(lebfl_pkg::MINIMAL_CAP));
    end else begin
      is_last = (cnt_inc == len);
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign fire     = (state == lebfl_pkg::S_EMIT) && out_free;
  assign in_stall = (state != lebfl_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lebfl_pkg::S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        lebfl_pkg::S_IDLE: begin
          if (accept) begin
            state <= lebfl_pkg::S_EMIT;
            cnt   <= '0;
          end
        end
        lebfl_pkg::S_EMIT: begin
          if (fire) begin
            cnt <= cnt_inc;
            if (is_last) begin
              state <= lebfl_pkg::S_IDLE;
            end
          end
        end
        default: state <= lebfl_pkg::S_IDLE;
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (accept) begin
      v   <= value;
      sgn <= signed_mode;
      len <= len_next;
    end else if (fire) begin
      v <= rest;
    end
    if (fire) begin
      out_byte     <= is_last ? {1'b0, byte_lo} : (lebfl_pkg::CONT_BIT | {1'b0, byte_lo});
      last_byte    <= is_last;
      length_error <= is_last && !minimal && !stop;
    end
  end

  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> last_byte)
    else $error("length error on a non-final byte");

  a_cont_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_byte[7] == !last_byte))
    else $error("continuation bit disagrees with last flag");

  a_err_fixed_only: assert property (@(posedge clk) disable iff (rst)
    fire && is_last && !minimal && !stop |=> out_valid && length_error)
    else $error("length error lost");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == lebfl_pkg::S_EMIT |-> 32'(cnt) < lebfl_pkg::MAX_FIXED_LENGTH)
    else $error("byte count beyond limit");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("accepted a word without going busy");

endmodule
